FILE: rtl/core/fdt_pkg.sv
// ---------------------------------------------------------------------------
// fdt_pkg
// Shared constants and codes for the flood dedup / TTL filter.
// ---------------------------------------------------------------------------
package fdt_pkg;

	localparam int SEEN_DEPTH = 16;
	localparam int PTR_W      = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;
	localparam int ID_W       = 32;
	localparam int TTL_W      = 8;
	localparam int VERDICT_W  = 3;
	localparam int REQ_W      = 2;

	localparam logic [TTL_W-1:0] DEFAULT_TTL_RST = TTL_W'(5);

	typedef enum logic [REQ_W-1:0] {
		REQ_RECV  = 2'd0,
		REQ_ORIG  = 2'd1,
		REQ_CLEAR = 2'd2
	} req_t;

	typedef enum logic [VERDICT_W-1:0] {
		V_DUP      = 3'd0,
		V_NEW_STOP = 3'd1,
		V_NEW_FWD  = 3'd2,
		V_ORIG     = 3'd3,
		V_CLEAR    = 3'd4
	} verdict_t;

endpackage

FILE: rtl/core/flood_dedup_ttl_filter_unit.sv
// ---------------------------------------------------------------------------
// flood_dedup_ttl_filter_unit
// Duplicate suppression cache with hop-count handling for mesh flooding.
// ---------------------------------------------------------------------------
// Usage:
//   Command channel: an item (req_type, msg_id, ttl) is taken on a rising
//   edge with start high and busy low. busy is always low, so one item can
//   be issued every cycle.
//   Result channel: done pulses for one cycle with verdict and out_ttl.
//   The receiver cannot stall; each result is shown exactly once.
//   Result path: input register, then compare/update and result register.
//   Throughput: one item per cycle, as msg_id is compared against all ring
//   entries in parallel, combinationally, alongside the ring write.
//   An item with an unused request code gives no done pulse.
//   Configuration: cfg_we writes cfg_data into default_ttl on that edge;
//   write only while no item is in flight.
//   Reset (arst_n low): ring entries and write pointer go to zero (id 0 then
//   counts as seen), default_ttl goes to 5, no result pending.
// ---------------------------------------------------------------------------
module flood_dedup_ttl_filter_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [fdt_pkg::REQ_W-1:0]     req_type,
	input  logic [fdt_pkg::ID_W-1:0]      msg_id,
	input  logic [fdt_pkg::TTL_W-1:0]     ttl,
	input  logic                          cfg_we,
	input  logic [fdt_pkg::TTL_W-1:0]     cfg_data,
	output logic                          done,
	output logic [fdt_pkg::VERDICT_W-1:0] verdict,
	output logic [fdt_pkg::TTL_W-1:0]     out_ttl
);
	import fdt_pkg::*;

	logic                 valid_s1;
	logic [REQ_W-1:0]     req_s1;
	logic [ID_W-1:0]      id_s1;
	logic [TTL_W-1:0]     ttl_s1;

	logic [ID_W-1:0]      seen_q [SEEN_DEPTH];
	logic [PTR_W-1:0]     ptr_q;
	logic [TTL_W-1:0]     default_ttl_q;

	logic                 hit;
	logic                 do_write;
	logic                 do_clear;
	logic                 res_valid;
	logic [VERDICT_W-1:0] res_verdict;
	logic [TTL_W-1:0]     res_ttl;
	logic [PTR_W-1:0]     ptr_next;

	assign busy = 1'b0;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			req_s1 <= req_type;
			id_s1  <= msg_id;
			ttl_s1 <= ttl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_ttl_q <= DEFAULT_TTL_RST;
		end else if (cfg_we) begin
			default_ttl_q <= cfg_data;
		end
	end

	// parallel compare against every ring entry
	always_comb begin
		hit = 1'b0;
		for (int i = 0; i < SEEN_DEPTH; i++) begin
			if (seen_q[i] == id_s1) hit = 1'b1;
		end
	end

	always_comb begin
		do_write    = 1'b0;
		do_clear    = 1'b0;
		res_valid   = 1'b0;
		res_verdict = V_DUP;
		res_ttl     = '0;
		if (valid_s1) begin
			unique case (req_s1)
				REQ_RECV: begin
					res_valid = 1'b1;
					if (!hit) begin
						do_write = 1'b1;
						if (ttl_s1 > TTL_W'(1)) begin
							res_verdict = V_NEW_FWD;
							res_ttl     = ttl_s1 - TTL_W'(1);
						end else begin
							res_verdict = V_NEW_STOP;
						end
					end
				end
				REQ_ORIG: begin
					res_valid   = 1'b1;
					do_write    = 1'b1;
					res_verdict = V_ORIG;
					res_ttl     = (ttl_s1 != '0) ? ttl_s1 : default_ttl_q;
				end
				REQ_CLEAR: begin
					res_valid   = 1'b1;
					do_clear    = 1'b1;
					res_verdict = V_CLEAR;
				end
				default: begin
					res_valid = 1'b0;
				end
			endcase
		end
	end

	assign ptr_next = (ptr_q == PTR_W'(SEEN_DEPTH - 1)) ? '0 : ptr_q + PTR_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			for (int i = 0; i < SEEN_DEPTH; i++) seen_q[i] <= '0;
		end else if (do_clear) begin
			ptr_q <= '0;
			for (int i = 0; i < SEEN_DEPTH; i++) seen_q[i] <= '0;
		end else if (do_write) begin
			ptr_q <= ptr_next;
			for (int i = 0; i < SEEN_DEPTH; i++) begin
				if (ptr_q == PTR_W'(i)) seen_q[i] <= id_s1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			verdict <= res_verdict;
			out_ttl <= res_ttl;
		end
	end

	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid_s1))
		else $error("result without a registered item");

	a_clear_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && req_s1 == REQ_CLEAR) |=> (ptr_q == '0))
		else $error("write pointer not reset by clear");

	a_dup_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && req_s1 == REQ_RECV && hit) |=> (ptr_q == $past(ptr_q)))
		else $error("duplicate moved the write pointer");

	a_fwd_ttl: assert property (@(posedge clk) disable iff (!arst_n)
		(done && verdict == V_NEW_FWD) |-> (out_ttl != '0 && out_ttl != '1))
		else $error("forward ttl out of range");

	a_stored: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && req_s1 == REQ_ORIG) |=> (seen_q[$past(ptr_q)] == $past(id_s1)))
		else $error("originated id not stored");

endmodule

FILE: verif/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for flood_dedup_ttl_filter_unit: a queue-fed driver
// issues receive/originate/clear/unused items with random gaps, a software copy
// of the seen-id ring predicts each verdict and hop count, and a monitor
// checks every done pulse in order. default_ttl is rewritten between phases.
// ---------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import fdt_pkg::*;

	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 200;
	localparam int RAND_PHASE_ITEMS = 300;

	typedef struct {
		logic [REQ_W-1:0] req;
		logic [ID_W-1:0]  id;
		logic [TTL_W-1:0] hops;
	} filter_cmd_t;

	typedef struct {
		verdict_t         v;
		logic [TTL_W-1:0] hops;
	} hop_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic [REQ_W-1:0]     req_type = '0;
	logic [ID_W-1:0]      msg_id = '0;
	logic [TTL_W-1:0]     ttl = '0;
	logic                 cfg_we = 1'b0;
	logic [TTL_W-1:0]     cfg_data = '0;
	logic                 done;
	logic [VERDICT_W-1:0] verdict;
	logic [TTL_W-1:0]     out_ttl;

	flood_dedup_ttl_filter_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req_type (req_type),
		.msg_id   (msg_id),
		.ttl      (ttl),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.done     (done),
		.verdict  (verdict),
		.out_ttl  (out_ttl)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow copy of the seen-id ring and the hop default
	logic [ID_W-1:0]  seen_ring [SEEN_DEPTH];
	int               ring_ptr;
	logic [TTL_W-1:0] dflt_hops;

	filter_cmd_t cmd_q[$];
	hop_result_t verdict_q[$];
	logic [ID_W-1:0] recent_ids[$];

	filter_cmd_t cur_cmd;
	hop_result_t mon_exp;
	int gap_left;
	int calm_left;
	int mismatch_cnt;
	int stall_cnt;

	task automatic ring_store(input logic [ID_W-1:0] id);
		seen_ring[ring_ptr] = id;
		ring_ptr = (ring_ptr + 1) % SEEN_DEPTH;
	endtask

	task automatic ring_wipe();
		for (int k = 0; k < SEEN_DEPTH; k++)
			seen_ring[k] = '0;
		ring_ptr = 0;
	endtask

	task automatic predict_item(input filter_cmd_t c);
		logic hit;
		hop_result_t r;
		hit = 1'b0;
		r.v = V_DUP;
		r.hops = '0;
		case (c.req)
			REQ_RECV: begin
				for (int k = 0; k < SEEN_DEPTH; k++)
					if (seen_ring[k] == c.id)
						hit = 1'b1;
				if (!hit) begin
					ring_store(c.id);
					if (c.hops > 1) begin
						r.v = V_NEW_FWD;
						r.hops = c.hops - 1'b1;
					end else begin
						r.v = V_NEW_STOP;
					end
				end
				verdict_q.push_back(r);
			end
			REQ_ORIG: begin
				// originate writes the id without looking it up
				ring_store(c.id);
				r.v = V_ORIG;
				r.hops = (c.hops != '0) ? c.hops : dflt_hops;
				verdict_q.push_back(r);
			end
			REQ_CLEAR: begin
				ring_wipe();
				r.v = V_CLEAR;
				verdict_q.push_back(r);
			end
			default: begin
			end
		endcase
	endtask

	// driver: one item per handshake, random gap before the next
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				predict_item(cur_cmd);
			if (!(start && busy)) begin
				if (gap_left > 0) begin
					start <= 1'b0;
					gap_left--;
				end else if (cmd_q.size() > 0) begin
					cur_cmd = cmd_q.pop_front();
					start <= 1'b1;
					req_type <= cur_cmd.req;
					msg_id <= cur_cmd.id;
					ttl <= cur_cmd.hops;
					if (calm_left > 0) begin
						calm_left--;
						gap_left = 0;
					end else begin
						gap_left = $urandom_range(0, 5);
						if ($urandom_range(0, 15) == 0)
							calm_left = $urandom_range(10, 40);
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: results cannot be held off, check each one on its pulse
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (verdict_q.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("unexpected result: verdict %0d out_ttl %0d", verdict, out_ttl);
			end else begin
				mon_exp = verdict_q.pop_front();
				if (verdict !== mon_exp.v || out_ttl !== mon_exp.hops) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("mismatch: verdict exp %0d got %0d, out_ttl exp %0d got %0d",
							mon_exp.v, verdict, mon_exp.hops, out_ttl);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				stall_cnt = 0;
			else
				stall_cnt++;
			if (stall_cnt >= STALL_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	task automatic add_cmd(input logic [REQ_W-1:0] req, input logic [ID_W-1:0] id,
			input logic [TTL_W-1:0] hops);
		filter_cmd_t c;
		c.req = req;
		c.id = id;
		c.hops = hops;
		cmd_q.push_back(c);
	endtask

	// sender holds off until every queued item is issued and every result is back
	task automatic drain();
		while (!(cmd_q.size() == 0 && !start && verdict_q.size() == 0))
			@(negedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_default(input logic [TTL_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		dflt_hops = v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic add_random_cmd();
		logic [REQ_W-1:0] req;
		logic [ID_W-1:0] id;
		logic [TTL_W-1:0] hops;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			req = REQ_RECV;
		else if (pick < 90)
			req = REQ_ORIG;
		else if (pick < 93)
			req = REQ_CLEAR;
		else if (pick < 96)
			req = REQ_UNUSED;
		else
			req = REQ_RECV;
		pick = $urandom_range(0, 9);
		if (pick < 4 && recent_ids.size() > 0)
			id = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
		else if (pick == 4)
			id = '0;
		else if (pick == 5)
			id = '1;
		else
			id = $urandom;
		pick = $urandom_range(0, 7);
		case (pick)
			0: hops = 8'd0;
			1: hops = 8'd1;
			2: hops = 8'd2;
			3: hops = 8'd255;
			default: hops = TTL_W'($urandom_range(0, 255));
		endcase
		// ids revisited after more than SEEN_DEPTH inserts have been evicted
		recent_ids.push_back(id);
		if (recent_ids.size() > 2 * SEEN_DEPTH)
			void'(recent_ids.pop_front());
		add_cmd(req, id, hops);
	endtask

	logic [TTL_W-1:0] phase_dflt [6];

	initial begin
		ring_wipe();
		dflt_hops = DEFAULT_TTL_RST;
		gap_left = 0;
		calm_left = 0;
		mismatch_cnt = 0;
		stall_cnt = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset contents, extremes, every request code
		add_cmd(REQ_RECV, 32'h0000_0000, 8'd5);   // zeroed ring: id 0 is a dup
		add_cmd(REQ_RECV, 32'hFFFF_FFFF, 8'd255);
		add_cmd(REQ_RECV, 32'hFFFF_FFFF, 8'd255);
		add_cmd(REQ_RECV, 32'h0000_0001, 8'd1);
		add_cmd(REQ_RECV, 32'h0000_0002, 8'd0);
		add_cmd(REQ_RECV, 32'h0000_0003, 8'd2);
		add_cmd(REQ_ORIG, 32'hFFFF_FFFF, 8'd0);   // already seen, written again
		add_cmd(REQ_ORIG, 32'h0000_0004, 8'd255);
		add_cmd(REQ_ORIG, 32'h0000_0005, 8'd1);
		add_cmd(REQ_UNUSED, 32'h0000_0006, 8'd9);
		add_cmd(REQ_RECV, 32'h0000_0006, 8'd9);   // unused code left no trace
		add_cmd(REQ_CLEAR, 32'hA5A5_5A5A, 8'd77);
		add_cmd(REQ_RECV, 32'hFFFF_FFFF, 8'd3);
		add_cmd(REQ_RECV, 32'h0000_0000, 8'd3);
		drain();

		// default hop count at its extremes, including zero
		phase_dflt[0] = 8'd0;
		phase_dflt[1] = 8'd255;
		phase_dflt[2] = 8'd1;
		for (int p = 0; p < 3; p++) begin
			write_default(phase_dflt[p]);
			add_cmd(REQ_ORIG, 32'h0000_1000 + p, 8'd0);
			add_cmd(REQ_RECV, 32'h0000_1000 + p, 8'd9);
			drain();
		end

		phase_dflt[3] = TTL_W'($urandom_range(1, 254));
		phase_dflt[4] = TTL_W'($urandom_range(1, 254));
		phase_dflt[5] = DEFAULT_TTL_RST;
		for (int p = 0; p < 6; p++) begin
			write_default(phase_dflt[p]);
			for (int n = 0; n < RAND_PHASE_ITEMS; n++)
				add_random_cmd();
			drain();
		end

		repeat (5) @(posedge clk);
		if (mismatch_cnt == 0 && verdict_q.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
